// File: rtl/core/backup_charge_supervisor_unit_assert.svh
// Assertion macros for the backup charge supervisor.
`ifndef BACKUP_CHARGE_SUPERVISOR_UNIT_ASSERT_SVH
`define BACKUP_CHARGE_SUPERVISOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcs assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcs assertion failed: next-cycle implication");

`endif

// File: rtl/core/bcs_pkg.sv
// Package for the backup charge supervisor: widths, constants, register map, types.
`timescale 1ns / 1ps
`default_nettype none

package bcs_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned PERIOD_W   = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Default timing of the supervisor, in seconds.
  localparam logic [TIME_W-1:0] SAMPLE_PERIOD_S = TIME_W'(5);
  localparam logic [TIME_W-1:0] OFF_PULSE_S     = TIME_W'(1);

  // Register reset values.
  localparam logic [MV_W-1:0]     CHARGE_THR_RST    = MV_W'(16000);
  localparam logic [PERIOD_W-1:0] TOGGLE_PERIOD_RST = PERIOD_W'(3600);
  localparam logic [MV_W-1:0]     FLAG_THR_RST      = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARGE_THR    = 3'd0,
    CFG_TOGGLE_PERIOD = 3'd1,
    CFG_LOW_SET       = 3'd2,
    CFG_LOW_CLEAR     = 3'd3,
    CFG_CRIT_SET      = 3'd4,
    CFG_CRIT_CLEAR    = 3'd5,
    CFG_MANUAL_MODE   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [MV_W-1:0]     charge_thr_mv;
    logic [PERIOD_W-1:0] toggle_period_s;
    logic [MV_W-1:0]     low_set_mv;
    logic [MV_W-1:0]     low_clear_mv;
    logic [MV_W-1:0]     crit_set_mv;
    logic [MV_W-1:0]     crit_clear_mv;
    logic                manual_mode;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/bcs_if.sv
// Channel interfaces: tick input and status result.
`timescale 1ns / 1ps
`default_nettype none

interface bcs_tick_if;
  logic                        valid;
  logic                        ready;
  logic [bcs_pkg::TIME_W-1:0]  uptime_s;
  logic [bcs_pkg::MV_W-1:0]    storage_mv;
  logic [bcs_pkg::MV_W-1:0]    source_mv;
  logic                        manual_charge;

  modport source (output valid, uptime_s, storage_mv, source_mv, manual_charge,
                  input ready);
  modport sink   (input valid, uptime_s, storage_mv, source_mv, manual_charge,
                  output ready);
endinterface

interface bcs_result_if;
  logic valid;
  logic ready;
  logic charge_on;
  logic low_voltage;
  logic critical_voltage;
  logic sample_taken;

  modport source (output valid, charge_on, low_voltage, critical_voltage, sample_taken,
                  input ready);
  modport sink   (input valid, charge_on, low_voltage, critical_voltage, sample_taken,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/bcs_cfg_regs.sv
// Configuration register file of the backup charge supervisor.
`timescale 1ns / 1ps
`default_nettype none

module bcs_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output bcs_pkg::cfg_t                      cfg_o
);

  bcs_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bcs_pkg::CFG_CHARGE_THR:    cfg_d.charge_thr_mv   = cfg_wdata_i[bcs_pkg::MV_W-1:0];
        bcs_pkg::CFG_TOGGLE_PERIOD: cfg_d.toggle_period_s =
                                      cfg_wdata_i[bcs_pkg::PERIOD_W-1:0];
        bcs_pkg::CFG_LOW_SET:       cfg_d.low_set_mv      = cfg_wdata_i[bcs_pkg::MV_W-1:0];
        bcs_pkg::CFG_LOW_CLEAR:     cfg_d.low_clear_mv    = cfg_wdata_i[bcs_pkg::MV_W-1:0];
        bcs_pkg::CFG_CRIT_SET:      cfg_d.crit_set_mv     = cfg_wdata_i[bcs_pkg::MV_W-1:0];
        bcs_pkg::CFG_CRIT_CLEAR:    cfg_d.crit_clear_mv   = cfg_wdata_i[bcs_pkg::MV_W-1:0];
        bcs_pkg::CFG_MANUAL_MODE:   cfg_d.manual_mode     = cfg_wdata_i[0];
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charge_thr_mv   <= bcs_pkg::CHARGE_THR_RST;
      cfg_q.toggle_period_s <= bcs_pkg::TOGGLE_PERIOD_RST;
      cfg_q.low_set_mv      <= bcs_pkg::FLAG_THR_RST;
      cfg_q.low_clear_mv    <= bcs_pkg::FLAG_THR_RST;
      cfg_q.crit_set_mv     <= bcs_pkg::FLAG_THR_RST;
      cfg_q.crit_clear_mv   <= bcs_pkg::FLAG_THR_RST;
      cfg_q.manual_mode     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/backup_charge_supervisor_unit.sv
// Top level of the backup charge supervisor: tick pipeline, supervisor state, result register.
//
//   channel   dir   payload                                          handshake
//   tick_i    in    uptime_s, storage_mv, source_mv, manual_charge   valid/ready
//   result_o  out   charge_on, low_voltage, critical_voltage,        valid/ready
//                   sample_taken
//   cfg       in    cfg_idx_i, cfg_wdata_i                           cfg_we_i
//
// One transaction per cycle sustained while result_o.ready is high; a tick passes
// through the input register, then the update logic into the result register.
// The supervisor state is written as a tick moves into the result register, so
// the next tick in the input register already sees it.
// A stalled result holds the result register; the input register still takes one
// more tick, and only when both are full does tick_i.ready drop.
// Reset clears the pipeline valids, the supervisor state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "backup_charge_supervisor_unit_assert.svh"

module backup_charge_supervisor_unit #(
  parameter logic [bcs_pkg::TIME_W-1:0] SAMPLE_PERIOD_S = bcs_pkg::SAMPLE_PERIOD_S,
  parameter logic [bcs_pkg::TIME_W-1:0] OFF_PULSE_S     = bcs_pkg::OFF_PULSE_S
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bcs_tick_if.sink                       tick_i,
  bcs_result_if.source                   result_o,
  input  logic                           cfg_we_i,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned TW = bcs_pkg::TIME_W;
  localparam int unsigned MW = bcs_pkg::MV_W;

  bcs_pkg::cfg_t cfg;

  bcs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic          s1_valid_d, s1_valid_q;
  logic [TW-1:0] s1_uptime_q;
  logic [MW-1:0] s1_storage_q;
  logic [MW-1:0] s1_source_q;
  logic          s1_manual_q;
  logic          out_valid_d, out_valid_q;
  logic          s1_adv;
  logic          in_fire;

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv       = s1_valid_q && (!out_valid_q || result_o.ready);
  assign tick_i.ready = !s1_valid_q || s1_adv;
  assign in_fire      = tick_i.valid && tick_i.ready;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_uptime_q  <= tick_i.uptime_s;
      s1_storage_q <= tick_i.storage_mv;
      s1_source_q  <= tick_i.source_mv;
      s1_manual_q  <= tick_i.manual_charge;
    end
  end

  // ---------------------------------------------------------------------------
  // Supervisor state and per-tick update
  // ---------------------------------------------------------------------------
  logic [TW-1:0] next_sample_d, next_sample_q;
  logic [MW-1:0] held_src_d, held_src_q;
  logic [TW-1:0] last_toggle_d, last_toggle_q;
  logic [TW-1:0] next_toggle_d, next_toggle_q;
  logic          low_flag_d, low_flag_q;
  logic          crit_flag_d, crit_flag_q;
  logic          charge_d, charge_q;

  logic          sample_hit;
  logic          toggle_hit;
  logic [TW-1:0] sample_due;
  logic [TW-1:0] pulse_end;

  assign sample_hit = s1_uptime_q >= next_sample_q;
  assign sample_due = s1_uptime_q + SAMPLE_PERIOD_S;
  assign toggle_hit = s1_uptime_q >= next_toggle_q;

  // pulse end from the toggle time this tick leaves behind; wraps modulo 2^32
  assign pulse_end = (toggle_hit ? s1_uptime_q : last_toggle_q) + OFF_PULSE_S;

  always_comb begin
    next_sample_d = next_sample_q;
    held_src_d    = held_src_q;
    low_flag_d    = low_flag_q;
    crit_flag_d   = crit_flag_q;
    last_toggle_d = last_toggle_q;
    next_toggle_d = next_toggle_q;
    charge_d      = charge_q;

    // sampling comes first; clear wins over set when thresholds cross
    if (sample_hit) begin
      next_sample_d = sample_due;
      held_src_d    = s1_source_q;
      if (s1_storage_q < cfg.low_set_mv)    low_flag_d  = 1'b1;
      if (s1_storage_q > cfg.low_clear_mv)  low_flag_d  = 1'b0;
      if (s1_storage_q < cfg.crit_set_mv)   crit_flag_d = 1'b1;
      if (s1_storage_q > cfg.crit_clear_mv) crit_flag_d = 1'b0;
    end

    if (cfg.manual_mode) begin
      charge_d = s1_manual_q;
    end else begin
      // forced-off pulse starts at each toggle point
      if (toggle_hit) begin
        last_toggle_d = s1_uptime_q;
        next_toggle_d = s1_uptime_q + TW'(cfg.toggle_period_s);
        charge_d      = 1'b0;
      end
      if (s1_uptime_q >= pulse_end) begin
        charge_d = (held_src_d >= cfg.charge_thr_mv);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic res_charge_q, res_low_q, res_crit_q, res_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      next_sample_q <= '0;
      held_src_q    <= '0;
      last_toggle_q <= '0;
      next_toggle_q <= '0;
      low_flag_q    <= 1'b0;
      crit_flag_q   <= 1'b0;
      charge_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        next_sample_q <= next_sample_d;
        held_src_q    <= held_src_d;
        last_toggle_q <= last_toggle_d;
        next_toggle_q <= next_toggle_d;
        low_flag_q    <= low_flag_d;
        crit_flag_q   <= crit_flag_d;
        charge_q      <= charge_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_charge_q <= charge_d;
      res_low_q    <= low_flag_d;
      res_crit_q   <= crit_flag_d;
      res_sample_q <= sample_hit;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.charge_on        = res_charge_q;
  assign result_o.low_voltage      = res_low_q;
  assign result_o.critical_voltage = res_crit_q;
  assign result_o.sample_taken     = res_sample_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BCS_ASSERT_IMPL(a_ready_low_only_full, clk_i, rst_ni, !tick_i.ready, s1_valid_q && out_valid_q && !result_o.ready)
  `BCS_ASSERT_NEXT(a_adv_fills_result, clk_i, rst_ni, s1_adv, out_valid_q)
  `BCS_ASSERT_NEXT(a_manual_follows_bit, clk_i, rst_ni, s1_adv && cfg.manual_mode, res_charge_q == $past(s1_manual_q))
  `BCS_ASSERT_NEXT(a_sample_reschedules, clk_i, rst_ni, s1_adv && sample_hit, next_sample_q == $past(sample_due))

endmodule

`default_nettype wire
